>>> rtl/ayrs_pkg.sv
package ayrs_pkg;

    localparam int FIELD_W    = 32;
    localparam int IN_FIELDS  = 5;
    localparam int IN_TDATA_W = FIELD_W * IN_FIELDS;

    localparam int COEF_W = 33;
    localparam int PART_W = 48;
    localparam int SUM_W  = 51;

    localparam int GRID_W  = 9;
    localparam int SCALE_W = 33;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;

    localparam logic REG_GRID_SIZE  = 1'b0;
    localparam logic REG_MESH_SCALE = 1'b1;

    localparam logic [GRID_W-1:0]  GRID_SIZE_RST  = 9'd256;
    localparam logic [SCALE_W-1:0] MESH_SCALE_RST = 33'd66051;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef struct packed {
        logic first;
        logic last;
    } row_pos_t;

endpackage

>>> rtl/ayrs_ram.sv
module ayrs_ram
#(
    parameter int WIDTH = 113,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/adi_y_sweep_rhs_stencil_unit.sv
// Y-direction right-hand side stencil for an ADI sweep on an N x N x N grid. Grid points
// stream in x-fastest order, one item per cycle while s_axis_tready is high, no gaps needed.
// Each result is mesh_scale*mid + main*u + sub*u(y-1) + super*u(y+1), with the missing
// neighbor mirrored on the first and last rows; a point's result leaves one row later, when
// u(y+1) arrives. Items of the first row give no result, middle rows give one (tlast high)
// and the last row gives two, the point above and then the point itself, so that row is paced
// by the single output port. Results pass through the input stage, the product stage and the
// result queue. The row history sits in one line-buffer RAM with one write and one registered
// read per cycle, read by the item N places later; it needs no clearing after reset, and
// writing grid_size restarts the scan at the grid origin. Inputs are Q16.16; products are
// rounded half up to Q16.16 and the result saturates to DATA_WIDTH bits.
module adi_y_sweep_rhs_stencil_unit
    import ayrs_pkg::*;
#(
    parameter int MAX_GRID   = 256,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // mid_value, u_value, sub_coef, main_coef, super_coef
    input  logic [IN_TDATA_W-1:0]             s_axis_tdata,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // rhs_value, zero padded to whole bytes
    output logic [((DATA_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
    output logic                              m_axis_tlast,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [APB_ADDR_W-1:0]             paddr,
    input  logic [APB_DATA_W-1:0]             pwdata,
    output logic [APB_DATA_W-1:0]             prdata,
    output logic                              pready
);

    localparam int XW     = $clog2(MAX_GRID);
    localparam int OUT_TW = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int RAM_W  = FIELD_W + PART_W + COEF_W;

    localparam logic signed [SUM_W-1:0] PART_HI =
        {{(SUM_W-PART_W+1){1'b0}}, {(PART_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] PART_LO =
        {{(SUM_W-PART_W+1){1'b1}}, {(PART_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] DATA_HI =
        {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] DATA_LO =
        {{(SUM_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    localparam logic signed [65:0] HALF_SCALE = 66'sh0_8000_0000;
    localparam logic signed [63:0] HALF_MAIN  = 64'sh8000;
    localparam logic signed [64:0] HALF_COEF  = 65'sh8000;

    function automatic logic signed [PART_W-1:0] sat_part(input logic signed [SUM_W-1:0] v);
        logic signed [PART_W-1:0] r;
        if (v > PART_HI)
        begin
            r = PART_HI[PART_W-1:0];
        end
        else if (v < PART_LO)
        begin
            r = PART_LO[PART_W-1:0];
        end
        else
        begin
            r = v[PART_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] sat_data(input logic signed [SUM_W-1:0] v);
        logic [DATA_WIDTH-1:0] r;
        if (v > DATA_HI)
        begin
            r = DATA_HI[DATA_WIDTH-1:0];
        end
        else if (v < DATA_LO)
        begin
            r = DATA_LO[DATA_WIDTH-1:0];
        end
        else
        begin
            r = v[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    // Configuration registers.
    logic               cfg_wr;
    logic [GRID_W-1:0]  grid_size_reg;
    logic [SCALE_W-1:0] mesh_scale_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg  <= GRID_SIZE_RST;
            mesh_scale_reg <= MESH_SCALE_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3])
                REG_GRID_SIZE:  grid_size_reg  <= pwdata[GRID_W-1:0];
                REG_MESH_SCALE: mesh_scale_reg <= pwdata[SCALE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3])
            REG_GRID_SIZE:  prdata = APB_DATA_W'(grid_size_reg);
            REG_MESH_SCALE: prdata = APB_DATA_W'(mesh_scale_reg);
            default:        prdata = '0;
        endcase
    end

    // Scan position.
    logic          s_acc;
    logic [XW-1:0] n_last;
    logic [XW-1:0] col_reg;
    logic [XW-1:0] row_reg;
    row_pos_t      in_pos;

    assign s_acc = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (grid_size_reg < GRID_W'(2))
        begin
            n_last = XW'(1);
        end
        else if (int'(grid_size_reg) > MAX_GRID)
        begin
            n_last = XW'(MAX_GRID - 1);
        end
        else
        begin
            n_last = XW'(grid_size_reg - GRID_W'(1));
        end
    end

    assign in_pos.first = (row_reg == '0);
    assign in_pos.last  = (row_reg == n_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_wr && paddr[3] == REG_GRID_SIZE)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (s_acc)
        begin
            if (col_reg == n_last)
            begin
                col_reg <= '0;
                row_reg <= (row_reg == n_last) ? '0 : row_reg + XW'(1);
            end
            else
            begin
                col_reg <= col_reg + XW'(1);
            end
        end
    end

    // Input stage.
    logic signed [FIELD_W-1:0] in_mid;
    logic signed [FIELD_W-1:0] in_u;
    logic signed [FIELD_W-1:0] in_sub;
    logic signed [FIELD_W-1:0] in_main;
    logic signed [FIELD_W-1:0] in_super;
    logic signed [COEF_W-1:0]  in_sum;

    assign in_mid   = s_axis_tdata[FIELD_W*0 +: FIELD_W];
    assign in_u     = s_axis_tdata[FIELD_W*1 +: FIELD_W];
    assign in_sub   = s_axis_tdata[FIELD_W*2 +: FIELD_W];
    assign in_main  = s_axis_tdata[FIELD_W*3 +: FIELD_W];
    assign in_super = s_axis_tdata[FIELD_W*4 +: FIELD_W];
    assign in_sum   = COEF_W'(in_sub) + COEF_W'(in_super);

    logic                      s1_valid_reg;
    row_pos_t                  s1_pos_reg;
    logic [XW-1:0]             s1_x_reg;
    logic signed [FIELD_W-1:0] s1_mid_reg;
    logic signed [FIELD_W-1:0] s1_u_reg;
    logic signed [FIELD_W-1:0] s1_main_reg;
    logic signed [COEF_W-1:0]  s1_nb_coef_reg;
    logic signed [COEF_W-1:0]  s1_pend_new_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_pos_reg      <= in_pos;
            s1_x_reg        <= col_reg;
            s1_mid_reg      <= in_mid;
            s1_u_reg        <= in_u;
            s1_main_reg     <= in_main;
            s1_nb_coef_reg  <= in_pos.last ? in_sum : COEF_W'(in_sub);
            s1_pend_new_reg <= in_pos.first ? in_sum : COEF_W'(in_super);
        end
    end

    // Line buffer: {pending coefficient, partial sum, u of the row above}.
    logic             ram_we;
    logic [XW-1:0]    ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic [RAM_W-1:0] ram_rdata;
    logic             fwd_hit_reg;
    logic [RAM_W-1:0] fwd_data_reg;
    logic [RAM_W-1:0] s1_line;

    ayrs_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_GRID)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_acc),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // With N = 2 an entry is read on the same edge at which it is written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= s_acc && ram_we && (ram_waddr == col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= ram_wdata;
    end

    assign s1_line = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    logic signed [FIELD_W-1:0] s1_prev_u;
    logic signed [PART_W-1:0]  s1_partial;
    logic signed [COEF_W-1:0]  s1_pending;
    logic signed [SCALE_W:0]   s1_scale;
    logic signed [65:0]        s1_p_scale;
    logic signed [63:0]        s1_p_main;
    logic signed [64:0]        s1_p_pend;
    logic signed [64:0]        s1_p_nb;

    assign s1_prev_u  = s1_line[0 +: FIELD_W];
    assign s1_partial = s1_line[FIELD_W +: PART_W];
    assign s1_pending = s1_line[FIELD_W+PART_W +: COEF_W];
    assign s1_scale   = {1'b0, mesh_scale_reg};

    assign s1_p_scale = s1_scale * s1_mid_reg;
    assign s1_p_main  = s1_main_reg * s1_u_reg;
    assign s1_p_pend  = s1_pending * s1_u_reg;
    assign s1_p_nb    = s1_nb_coef_reg * s1_prev_u;

    // Product stage.
    logic                      s2_valid_reg;
    row_pos_t                  s2_pos_reg;
    logic [XW-1:0]             s2_x_reg;
    logic signed [FIELD_W-1:0] s2_u_reg;
    logic signed [COEF_W-1:0]  s2_pend_new_reg;
    logic signed [PART_W-1:0]  s2_partial_reg;
    logic signed [65:0]        s2_p_scale_reg;
    logic signed [63:0]        s2_p_main_reg;
    logic signed [64:0]        s2_p_pend_reg;
    logic signed [64:0]        s2_p_nb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_pos_reg      <= s1_pos_reg;
            s2_x_reg        <= s1_x_reg;
            s2_u_reg        <= s1_u_reg;
            s2_pend_new_reg <= s1_pend_new_reg;
            s2_partial_reg  <= s1_partial;
            s2_p_scale_reg  <= s1_p_scale;
            s2_p_main_reg   <= s1_p_main;
            s2_p_pend_reg   <= s1_p_pend;
            s2_p_nb_reg     <= s1_p_nb;
        end
    end

    logic signed [33:0]       s2_r_scale;
    logic signed [47:0]       s2_r_main;
    logic signed [48:0]       s2_r_pend;
    logic signed [48:0]       s2_r_nb;
    logic signed [SUM_W-1:0]  s2_own;
    logic signed [SUM_W-1:0]  s2_with_nb;
    logic signed [SUM_W-1:0]  s2_above;
    logic signed [PART_W-1:0] s2_part_new;

    assign s2_r_scale = 34'((s2_p_scale_reg + HALF_SCALE) >>> 32);
    assign s2_r_main  = 48'((s2_p_main_reg + HALF_MAIN) >>> 16);
    assign s2_r_pend  = 49'((s2_p_pend_reg + HALF_COEF) >>> 16);
    assign s2_r_nb    = s2_pos_reg.first ? '0 : 49'((s2_p_nb_reg + HALF_COEF) >>> 16);

    assign s2_own      = SUM_W'(s2_r_scale) + SUM_W'(s2_r_main);
    assign s2_with_nb  = s2_own + SUM_W'(s2_r_nb);
    assign s2_above    = SUM_W'(s2_partial_reg) + SUM_W'(s2_r_pend);
    assign s2_part_new = sat_part(s2_with_nb);

    assign ram_we    = s2_valid_reg;
    assign ram_waddr = s2_x_reg;
    assign ram_wdata = {s2_pend_new_reg, s2_part_new, s2_u_reg};

    // Result queue; one entry holds all results of one item.
    logic                  fifo_push;
    logic                  fifo_pop;
    logic [DATA_WIDTH-1:0] fifo_a_reg   [FIFO_DEPTH];
    logic [DATA_WIDTH-1:0] fifo_b_reg   [FIFO_DEPTH];
    logic                  fifo_two_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] fifo_cnt_reg;
    logic [FIFO_CNT_W-1:0] fifo_cnt_next;
    logic                  sel_reg;
    logic                  head_two;
    logic [DATA_WIDTH-1:0] out_val;

    assign fifo_push = s2_valid_reg && !s2_pos_reg.first;
    assign head_two  = fifo_two_reg[rd_ptr_reg];
    assign fifo_pop  = m_axis_tvalid && m_axis_tready && (!head_two || sel_reg);

    always_comb
    begin
        fifo_cnt_next = fifo_cnt_reg;
        if (fifo_push && !fifo_pop)
        begin
            fifo_cnt_next = fifo_cnt_reg + FIFO_CNT_W'(1);
        end
        else if (!fifo_push && fifo_pop)
        begin
            fifo_cnt_next = fifo_cnt_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            sel_reg      <= 1'b0;
        end
        else
        begin
            fifo_cnt_reg <= fifo_cnt_next;
            if (fifo_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (fifo_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
                sel_reg    <= 1'b0;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                sel_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_push)
        begin
            fifo_a_reg[wr_ptr_reg]   <= sat_data(s2_above);
            fifo_b_reg[wr_ptr_reg]   <= sat_data(s2_with_nb);
            fifo_two_reg[wr_ptr_reg] <= s2_pos_reg.last;
        end
    end

    // Room is kept for every item still in the two stages.
    assign s_axis_tready = (fifo_cnt_reg + FIFO_CNT_W'(s1_valid_reg)
                            + FIFO_CNT_W'(s2_valid_reg)) < FIFO_CNT_W'(FIFO_DEPTH);

    assign out_val       = sel_reg ? fifo_b_reg[rd_ptr_reg] : fifo_a_reg[rd_ptr_reg];
    assign m_axis_tvalid = (fifo_cnt_reg != '0);
    assign m_axis_tdata  = OUT_TW'(out_val);
    assign m_axis_tlast  = !head_two || sel_reg;

endmodule

>>> rtl/ayrs_checker.sv
module ayrs_checker
    import ayrs_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [IN_TDATA_W-1:0]           s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [((DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input  logic                            m_axis_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [APB_ADDR_W-1:0]           paddr,
    input  logic [APB_DATA_W-1:0]           pwdata,
    input  logic [APB_DATA_W-1:0]           prdata,
    input  logic                            pready
);

    logic cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;

    ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("Stalled result item changed or was dropped.");

    // The first of a pair of results is always followed at once by the second.
    ap_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        |=> m_axis_tvalid && m_axis_tlast)
        else $error("Second result of a last-row item did not follow the first.");

    ap_grid_readback: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && paddr[3] == REG_GRID_SIZE
        |=> paddr[3] != REG_GRID_SIZE
            || prdata[GRID_W-1:0] == $past(pwdata[GRID_W-1:0]))
        else $error("grid_size does not read back the value written.");

    ap_scale_readback: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr && paddr[3] == REG_MESH_SCALE
        |=> paddr[3] != REG_MESH_SCALE
            || prdata[SCALE_W-1:0] == $past(pwdata[SCALE_W-1:0]))
        else $error("mesh_scale does not read back the value written.");

endmodule

bind adi_y_sweep_rhs_stencil_unit ayrs_checker #(.DATA_WIDTH(DATA_WIDTH)) u_ayrs_checker (.*);

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import ayrs_pkg::*;

    localparam int GRID_MAX = 256;
    localparam logic [APB_ADDR_W-1:0] GRID_ADDR  = {REG_GRID_SIZE, 3'b000};
    localparam logic [APB_ADDR_W-1:0] SCALE_ADDR = {REG_MESH_SCALE, 3'b000};
    localparam logic [31:0] EXTREMES [5] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                             32'hffff_ffff, 32'h0001_0000};
    localparam int GRID_PICK [10] = '{3, 1, 5, 2, 4, 7, 12, 6, 9, 37};

    typedef struct {
        logic [31:0] rhs;
        logic        last;
    } rhs_item_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [31:0]             m_axis_tdata;
    logic                    m_axis_tlast;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    logic [IN_TDATA_W-1:0]   pending_items [$];
    rhs_item_t               rhs_expect [$];

    logic [8:0]              grid_q = 9'd256;
    logic [32:0]             scale_q = 33'd66051;
    longint                  prev_u [GRID_MAX];
    longint                  part_row [GRID_MAX];
    longint                  pend_coef [GRID_MAX];
    int                      col_pos = 0;
    int                      row_pos = 0;

    int                      err_count = 0;
    int                      burst_left = 0;
    int                      gap_left = 0;
    int                      hold_left = 0;
    bit                      hold_done = 1'b0;
    int                      pattern_left = 0;
    int                      ready_pct = 100;

    adi_y_sweep_rhs_stencil_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic longint q16_mul_round(input longint a, input longint b, input int s);
        logic signed [127:0] pa;
        logic signed [127:0] pb;
        logic signed [127:0] p;
        pa = a;
        pb = b;
        p = pa * pb + (128'sd1 <<< (s - 1));
        p = p >>> s;
        return longint'(p);
    endfunction

    function automatic longint sat_to(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic int grid_in_use();
        if (grid_q < 2)
            return 2;
        if (grid_q > GRID_MAX)
            return GRID_MAX;
        return int'(grid_q);
    endfunction

    function automatic void push_rhs(input longint v, input logic last);
        rhs_item_t r;
        r.rhs = 32'(sat_to(v, 32));
        r.last = last;
        rhs_expect.push_back(r);
    endfunction

    task automatic stencil_step(input logic [IN_TDATA_W-1:0] d);
        longint mid;
        longint u_cur;
        longint sub_c;
        longint main_c;
        longint sup_c;
        longint own;
        longint above;
        int n;
        int x;
        int y;
        mid = $signed(d[31:0]);
        u_cur = $signed(d[63:32]);
        sub_c = $signed(d[95:64]);
        main_c = $signed(d[127:96]);
        sup_c = $signed(d[159:128]);
        n = grid_in_use();
        x = (col_pos >= n) ? 0 : col_pos;
        y = (row_pos >= n) ? 0 : row_pos;
        own = q16_mul_round(longint'(scale_q), mid, 32) + q16_mul_round(main_c, u_cur, 16);
        if (y == 0)
        begin
            part_row[x] = sat_to(own, 48);
            pend_coef[x] = sub_c + sup_c;
        end
        else
        begin
            above = part_row[x] + q16_mul_round(pend_coef[x], u_cur, 16);
            if (y < n - 1)
            begin
                push_rhs(above, 1'b1);
                part_row[x] = sat_to(own + q16_mul_round(sub_c, prev_u[x], 16), 48);
                pend_coef[x] = sup_c;
            end
            else
            begin
                push_rhs(above, 1'b0);
                push_rhs(own + q16_mul_round(sub_c + sup_c, prev_u[x], 16), 1'b1);
            end
        end
        prev_u[x] = u_cur;
        x++;
        if (x >= n)
        begin
            x = 0;
            y++;
            if (y >= n)
                y = 0;
        end
        col_pos = x;
        row_pos = y;
    endtask

    function automatic logic [31:0] random_field();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return EXTREMES[$urandom_range(0, 4)];
            default: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
        endcase
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_item();
        logic [IN_TDATA_W-1:0] item;
        for (int k = 0; k < IN_FIELDS; k++)
            item[k*FIELD_W +: FIELD_W] = random_field();
        return item;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] extreme_item(input int i);
        logic [IN_TDATA_W-1:0] item;
        for (int k = 0; k < IN_FIELDS; k++)
            item[k*FIELD_W +: FIELD_W] = EXTREMES[(i * (k + 1) + k) % 5];
        return item;
    endfunction

    function automatic logic [32:0] scale_pick(input int n);
        case ($urandom_range(0, 4))
            0: return 33'd0;
            1: return 33'h1_0000_0000;
            2: return {1'b0, 32'($urandom)};
            default: return 33'h1_0000_0000 / 33'((n - 1) * (n - 1));
        endcase
    endfunction

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == GRID_ADDR)
        begin
            grid_q = data[8:0];
            col_pos = 0;
            row_pos = 0;
        end
        else if (addr == SCALE_ADDR)
        begin
            scale_q = data[32:0];
        end
    endtask

    task automatic load_items(input int count);
        @(negedge clk);
        for (int i = 0; i < count; i++)
            pending_items.push_back(random_item());
    endtask

    task automatic settle();
        @(negedge clk);
        while (pending_items.size() != 0 || s_axis_tvalid || rhs_expect.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    always @(posedge clk)
    begin : item_driver
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                stencil_step(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_items.pop_front();
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 48);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : rhs_monitor
        rhs_item_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (rhs_expect.size() == 0)
                begin
                    $error("rhs_value: no item expected, actual %h", m_axis_tdata);
                    err_count++;
                end
                else
                begin
                    want = rhs_expect.pop_front();
                    if (m_axis_tdata !== want.rhs)
                    begin
                        $error("rhs_value: expected %h, actual %h", want.rhs, m_axis_tdata);
                        err_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last_of_run: expected %b, actual %b", want.last, m_axis_tlast);
                        err_count++;
                    end
                end
            end

            // One long hold-off while items keep coming, so the block backs up.
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && pending_items.size() > 80 && rhs_expect.size() > 0)
            begin
                hold_done = 1'b1;
                hold_left = 250;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern_left = $urandom_range(20, 120);
                    case ($urandom_range(0, 3))
                        0: ready_pct = 100;
                        1: ready_pct = 80;
                        2: ready_pct = 50;
                        default: ready_pct = 20;
                    endcase
                end
                else
                begin
                    pattern_left--;
                end
                m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    initial
    begin : stimulus
        int n;
        int count;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        load_items(258);
        settle();

        apb_write(GRID_ADDR, 64'd3);
        apb_write(SCALE_ADDR, 64'h1_0000_0000);
        @(negedge clk);
        for (int i = 0; i < 18; i++)
            pending_items.push_back(extreme_item(i));
        settle();

        apb_write(GRID_ADDR, 64'd0);
        apb_write(SCALE_ADDR, 64'd0);
        @(negedge clk);
        for (int i = 0; i < 4; i++)
            pending_items.push_back(extreme_item(i + 7));
        settle();

        apb_write(GRID_ADDR, 64'd511);
        apb_write(SCALE_ADDR, 64'(scale_pick(256)));
        load_items(262);
        settle();

        for (int p = 0; p < 10; p++)
        begin
            if (p == 0 || $urandom_range(0, 3) != 0)
                apb_write(GRID_ADDR, 64'(GRID_PICK[p]));
            n = grid_in_use();
            apb_write(SCALE_ADDR, 64'(scale_pick(n)));
            count = $urandom_range(n * n, 2 * n * n);
            if (count > 40)
                count = $urandom_range(2 * n + 1, 40);
            if (p == 0)
                count = 120;
            load_items(count);
            settle();
        end

        repeat (10) @(negedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/ayrs_pkg.sv
rtl/ayrs_ram.sv
rtl/adi_y_sweep_rhs_stencil_unit.sv
rtl/ayrs_checker.sv
test/tb.sv
